@@ hdl/iqs_pkg.sv @@
`timescale 1ns / 1ps
package iqs_pkg;
    localparam int SampleBits  = 16;
    localparam int CordicSteps = 16;
    localparam logic [23:0] MaxSamples = 24'd10000000;
    localparam int WRegW = 41;
    localparam int IdxW  = 2;

    typedef enum logic [1:0] {
        REG_RATE = 2'd0, REG_BAND_LO = 2'd1, REG_BAND_HI = 2'd2, REG_MAG = 2'd3
    } t_reg_idx;

    typedef enum logic [1:0] {
        ST_OK = 2'd0, ST_TOO_MANY = 2'd1, ST_BAND_BAD = 2'd2
    } t_status;

    // one queued sample after classification
    typedef struct packed {
        logic        in_band;
        logic        bad;
        logic [31:0] power;
        logic        last;
    } t_cls;

    // statistics snapshot handed to the divide unit
    typedef struct packed {
        logic        ovf;
        logic        band_ok;
        logic [23:0] n;
        logic [23:0] band_n;
        logic [23:0] bad_n;
        logic [54:0] psum;
        logic [31:0] peak;
    } t_snap;

    typedef struct packed {
        logic [1:0]  status;
        logic [23:0] sample_total;
        logic [16:0] band_fraction;
        logic [16:0] clean_share;
        logic [31:0] power_avg;
        logic [15:0] peak_amp;
    } t_res;

    function automatic logic [16:0] turn_angle(input logic [4:0] k);
        logic [16:0] a;
        begin
            case (k)
                5'd0: a = 17'd8192;  5'd1: a = 17'd4836;  5'd2: a = 17'd2555;
                5'd3: a = 17'd1297;  5'd4: a = 17'd651;   5'd5: a = 17'd326;
                5'd6: a = 17'd163;   5'd7: a = 17'd81;    5'd8: a = 17'd41;
                5'd9: a = 17'd20;    5'd10: a = 17'd10;   5'd11: a = 17'd5;
                5'd12: a = 17'd3;    5'd13: a = 17'd1;    5'd14: a = 17'd1;
                default: a = 17'd0;
            endcase
            return a;
        end
    endfunction
endpackage

@@ hdl/iqs_stream_if.sv @@
`timescale 1ns / 1ps
interface iqs_stream_if #(parameter int W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ hdl/iqs_front.sv @@
`timescale 1ns / 1ps
// Sequential CORDIC phase, band test and power per sample.
module iqs_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic signed [15:0]   i_i,
    input  logic signed [15:0]   i_q,
    input  logic                 i_last,
    input  logic [39:0]          i_rate,
    input  logic signed [40:0]   i_lo,
    input  logic signed [40:0]   i_hi,
    input  logic [15:0]          i_mag,
    output logic                 o_valid,
    input  logic                 i_ready,
    output iqs_pkg::t_cls        o_cls
);
    typedef enum logic [2:0] {S_IDLE, S_ROT, S_MUL, S_CMP, S_OUT} t_state;
    t_state r_state;
    logic signed [42:0] r_x, r_y;
    logic signed [17:0] r_z;
    logic [4:0]  r_k;
    logic        r_last, r_zero;
    logic [31:0] r_pow;
    logic signed [58:0] r_f;
    iqs_pkg::t_cls r_cls;
    logic signed [42:0] dx, dy;
    logic signed [17:0] zc;
    logic signed [31:0] lim2;

    assign dx = r_y >>> r_k;
    assign dy = r_x >>> r_k;
    assign zc = (r_z > 18'sd32768) ? 18'sd32768 :
                (r_z < -18'sd32768) ? -18'sd32768 : r_z;
    assign lim2 = $signed({16'd0, i_mag} * {16'd0, i_mag});
    assign o_ready = (r_state == S_IDLE);
    assign o_valid = (r_state == S_OUT);
    assign o_cls = r_cls;

    // run rotate steps, then scale and compare
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: if (i_valid) begin
                    r_last <= i_last;
                    r_zero <= (i_i == 16'sd0) && (i_q == 16'sd0);
                    r_pow  <= 32'($signed(i_i) * $signed(i_i))
                            + 32'($signed(i_q) * $signed(i_q));
                    r_k    <= 5'd0;
                    if (i_i < 0) begin
                        r_x <= -(43'(i_i) <<< 24);
                        r_y <= -(43'(i_q) <<< 24);
                        r_z <= (i_q >= 0) ? 18'sd32768 : -18'sd32768;
                    end else begin
                        r_x <= 43'(i_i) <<< 24;
                        r_y <= 43'(i_q) <<< 24;
                        r_z <= 18'sd0;
                    end
                    r_state <= S_ROT;
                end
                S_ROT: begin
                    if (r_y > 0) begin
                        r_x <= r_x + dx; r_y <= r_y - dy;
                        r_z <= r_z + $signed({1'b0, iqs_pkg::turn_angle(r_k)});
                    end else begin
                        r_x <= r_x - dx; r_y <= r_y + dy;
                        r_z <= r_z - $signed({1'b0, iqs_pkg::turn_angle(r_k)});
                    end
                    r_k <= r_k + 5'd1;
                    if (r_k == 5'(iqs_pkg::CordicSteps - 1)) r_state <= S_MUL;
                end
                S_MUL: begin
                    r_f <= r_zero ? 59'sd0 : 59'(zc * $signed({1'b0, i_rate}));
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_cls.in_band <= (r_f >= (59'(i_lo) <<< 16))
                                  && (r_f <= (59'(i_hi) <<< 16));
                    r_cls.bad   <= r_pow > 32'(lim2);
                    r_cls.power <= r_pow;
                    r_cls.last  <= r_last;
                    r_state <= S_OUT;
                end
                S_OUT: if (i_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

@@ hdl/iqs_queue.sv @@
`timescale 1ns / 1ps
// Two-entry queue between front and back.
module iqs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  iqs_pkg::t_cls  i_data,
    output logic           o_valid,
    input  logic           i_ready,
    output iqs_pkg::t_cls  o_data
);
    iqs_pkg::t_cls r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    logic push, pop;
    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rp];
    assign push = i_valid && o_ready;
    assign pop  = o_valid && i_ready;
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_data;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + 2'(push) - 2'(pop);
        end
    end
endmodule

@@ hdl/iqs_back.sv @@
`timescale 1ns / 1ps
// Accumulate statistics; on last, run serial divides and square root.
module iqs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  iqs_pkg::t_cls  i_cls,
    input  logic           i_band_ok,
    output logic           o_valid,
    input  logic           i_ready,
    output iqs_pkg::t_res  o_res
);
    typedef enum logic [2:0] {S_ACC, S_D1, S_D2, S_D3, S_SQ, S_OUT} t_state;
    t_state r_state;
    logic [23:0] r_n, r_band, r_bad;
    logic [54:0] r_psum;
    logic [31:0] r_peak;
    logic        r_ovf;
    iqs_pkg::t_snap r_snap;
    logic [54:0] r_num, r_quo;
    logic [24:0] r_rem;
    logic [5:0]  r_cnt;
    logic [31:0] r_sv;
    logic [15:0] r_root;
    logic [18:0] r_sr;
    iqs_pkg::t_res r_res;
    logic [24:0] trial;
    logic [18:0] strial, srem;

    assign o_ready = (r_state == S_ACC);
    assign o_valid = (r_state == S_OUT);
    assign o_res = r_res;
    assign trial = {r_rem[23:0], r_num[54]};
    assign srem  = {r_sr[16:0], r_sv[31:30]};
    assign strial = {1'b0, r_root, 2'b01};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACC;
            r_n <= '0; r_band <= '0; r_bad <= '0; r_psum <= '0; r_peak <= '0;
            r_ovf <= 1'b0;
        end else begin
            unique case (r_state)
                S_ACC: if (i_valid) begin
                    if (i_cls.last) begin
                        r_snap.ovf <= r_ovf || (r_n >= iqs_pkg::MaxSamples);
                        if (r_n < iqs_pkg::MaxSamples) begin
                            r_snap.n <= r_n + 24'd1;
                            r_snap.band_n <= r_band + 24'(i_cls.in_band);
                            r_snap.bad_n <= r_bad + 24'(i_cls.bad);
                            r_snap.psum <= r_psum + 55'(i_cls.power);
                            r_snap.peak <= (i_cls.power > r_peak) ? i_cls.power
                                                                   : r_peak;
                        end else begin
                            r_snap.n <= r_n; r_snap.band_n <= r_band;
                            r_snap.bad_n <= r_bad; r_snap.psum <= r_psum;
                            r_snap.peak <= r_peak;
                        end
                        r_snap.band_ok <= i_band_ok;
                        r_n <= '0; r_band <= '0; r_bad <= '0; r_psum <= '0;
                        r_peak <= '0; r_ovf <= 1'b0;
                        r_state <= S_D1;
                        r_cnt <= 6'd0;
                    end else if (r_n >= iqs_pkg::MaxSamples) begin
                        r_ovf <= 1'b1;
                    end else begin
                        r_n <= r_n + 24'd1;
                        r_band <= r_band + 24'(i_cls.in_band);
                        r_bad  <= r_bad + 24'(i_cls.bad);
                        r_psum <= r_psum + 55'(i_cls.power);
                        if (i_cls.power > r_peak) r_peak <= i_cls.power;
                    end
                end
                S_D1, S_D2, S_D3: begin
                    if (r_cnt == 6'd0) begin
                        r_rem <= '0; r_quo <= '0;
                        unique case (r_state)
                            S_D1: r_num <= {15'd0, r_snap.band_n, 16'd0};
                            S_D2: r_num <= {15'd0, r_snap.n - r_snap.bad_n, 16'd0};
                            default: r_num <= r_snap.psum;
                        endcase
                        r_cnt <= 6'd1;
                    end else begin
                        if (trial >= {1'b0, r_snap.n}) begin
                            r_rem <= trial - {1'b0, r_snap.n};
                            r_quo <= {r_quo[53:0], 1'b1};
                        end else begin
                            r_rem <= trial;
                            r_quo <= {r_quo[53:0], 1'b0};
                        end
                        r_num <= {r_num[53:0], 1'b0};
                        if (r_cnt == 6'd55) r_cnt <= 6'd0;
                        else r_cnt <= r_cnt + 6'd1;
                    end
                    if (r_cnt == 6'd55) begin
                        unique case (r_state)
                            S_D1: begin
                                r_res.band_fraction <= {r_quo[15:0], trial >= {1'b0, r_snap.n}};
                                r_state <= S_D2;
                            end
                            S_D2: begin
                                r_res.clean_share <= {r_quo[15:0], trial >= {1'b0, r_snap.n}};
                                r_state <= S_D3;
                            end
                            default: begin
                                r_res.power_avg <= (r_quo[53:31] != '0) ? 32'hFFFFFFFF
                                    : {r_quo[30:0], trial >= {1'b0, r_snap.n}};
                                r_sv <= r_snap.peak; r_root <= '0; r_sr <= '0;
                                r_state <= S_SQ;
                            end
                        endcase
                    end
                end
                S_SQ: begin
                    if (srem >= strial) begin
                        r_sr <= srem - strial; r_root <= {r_root[14:0], 1'b1};
                    end else begin
                        r_sr <= srem; r_root <= {r_root[14:0], 1'b0};
                    end
                    r_sv <= {r_sv[29:0], 2'b00};
                    if (r_cnt == 6'd15) begin
                        r_cnt <= 6'd0;
                        r_state <= S_OUT;
                    end else begin
                        r_cnt <= r_cnt + 6'd1;
                    end
                end
                S_OUT: if (i_ready) r_state <= S_ACC;
                default: r_state <= S_ACC;
            endcase
            if (r_state == S_SQ && r_cnt == 6'd15) begin
                if (r_snap.ovf) begin
                    r_res.status <= iqs_pkg::ST_TOO_MANY;
                    r_res.sample_total <= iqs_pkg::MaxSamples + 24'd1;
                    r_res.band_fraction <= '0; r_res.clean_share <= '0;
                    r_res.power_avg <= '0; r_res.peak_amp <= '0;
                end else begin
                    r_res.status <= r_snap.band_ok ? iqs_pkg::ST_OK
                                                   : iqs_pkg::ST_BAND_BAD;
                    r_res.sample_total <= r_snap.n;
                    if (!r_snap.band_ok) r_res.band_fraction <= '0;
                    r_res.peak_amp <= {r_root[14:0], srem >= strial};
                end
            end
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> r_res.sample_total != 24'd0) else $error("zero total");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> o_valid) else $error("result dropped");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_n <= iqs_pkg::MaxSamples) else $error("count past limit");
endmodule

@@ hdl/iq_stream_statistics_top.sv @@
`timescale 1ns / 1ps
// channel  dir  payload
// s_in     in   i_sample[15:0] q_sample[15:0] last
// m_out    out  status sample_total band_fraction clean_share power_avg peak_amp
// cfg      in   i_cfg_we i_cfg_idx[1:0] i_cfg_data[40:0]
// A sample passes the serial CORDIC front end before the next sample is accepted.
// The last sample then runs through the shared bit-serial divider and root.
// Reset is synchronous active low and restores register defaults.
// Either side may stall; a two-entry queue decouples front and back.
module iq_stream_statistics_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    iqs_stream_if.sink        s_in,
    iqs_stream_if.source      m_out,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [40:0]       i_cfg_data
);
    logic [39:0] r_rate;
    logic signed [40:0] r_lo, r_hi;
    logic [15:0] r_mag;
    logic fv, fr, qv, qr;
    iqs_pkg::t_cls fc, qc;
    iqs_pkg::t_res res;

    // hold configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate <= 40'd1000000; r_lo <= -41'sd500000; r_hi <= 41'sd500000;
            r_mag <= 16'd1000;
        end else if (i_cfg_we) begin
            unique case (iqs_pkg::t_reg_idx'(i_cfg_idx))
                iqs_pkg::REG_RATE:    r_rate <= i_cfg_data[39:0];
                iqs_pkg::REG_BAND_LO: r_lo <= i_cfg_data;
                iqs_pkg::REG_BAND_HI: r_hi <= i_cfg_data;
                iqs_pkg::REG_MAG:     r_mag <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    iqs_front u_front (.i_clk, .i_rst_n, .i_valid(s_in.valid), .o_ready(s_in.ready),
        .i_i(s_in.data[32:17]), .i_q(s_in.data[16:1]), .i_last(s_in.data[0]),
        .i_rate(r_rate), .i_lo(r_lo), .i_hi(r_hi), .i_mag(r_mag),
        .o_valid(fv), .i_ready(fr), .o_cls(fc));
    iqs_queue u_queue (.i_clk, .i_rst_n, .i_valid(fv), .o_ready(fr), .i_data(fc),
        .o_valid(qv), .i_ready(qr), .o_data(qc));
    iqs_back u_back (.i_clk, .i_rst_n, .i_valid(qv), .o_ready(qr), .i_cls(qc),
        .i_band_ok(r_lo <= r_hi), .o_valid(m_out.valid), .i_ready(m_out.ready),
        .o_res(res));
    assign m_out.data = res;
endmodule

@@ tb/tb_iq_stream_statistics_top.sv @@
`timescale 1ns / 1ps
module tb_iq_stream_statistics_top;
    import iqs_pkg::*;

    localparam int InW        = 2 * SampleBits + 1;
    localparam int DrainWait  = 250;
    localparam int StallLimit = 5000;
    localparam int ItemTarget = 1400;

    typedef struct {
        logic signed [15:0] i_val;
        logic signed [15:0] q_val;
        bit                 last;
        bit                 typed;
        t_res               res;
    } t_row;

    // CORDIC angle steps in Q1.16 turns
    localparam longint TurnStep [24] = '{
        8192, 4836, 2555, 1297, 651, 326, 163, 81, 41, 20, 10, 5,
        3, 1, 1, 0, 0, 0, 0, 0, 0, 0, 0, 0
    };

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [1:0]        i_cfg_idx;
    logic [40:0]       i_cfg_data;

    iqs_stream_if #(.W(InW))          s_in ();
    iqs_stream_if #(.W($bits(t_res))) m_out ();

    iq_stream_statistics_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_in       (s_in),
        .m_out      (m_out),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // shadow of the block's registers and statistics
    longint rate_hz, band_lo_hz, band_hi_hz, mag_limit;
    longint n_samples, n_in_band, n_bad, power_acc, peak_pwr;
    bit     ovf_seen;

    t_res   pending_stats [$];
    int     err_count;
    int     samples_sent;
    int     idle_cycles;
    bit     hold_off;

    // directed rows; typed results cover reset defaults and the extremes
    t_row dir_rows [14] = '{
        '{16'sd0, 16'sd0, 1'b1, 1'b1, '{ST_OK, 24'd1, 17'd65536, 17'd65536, 32'd0, 16'd0}},
        '{-16'sd32768, -16'sd32768, 1'b1, 1'b1,
          '{ST_OK, 24'd1, 17'd65536, 17'd0, 32'd2147483648, 16'd46340}},
        '{16'sd32767, 16'sd0, 1'b1, 1'b0, '0},
        '{16'sd0, 16'sd32767, 1'b1, 1'b0, '0},
        '{-16'sd32768, 16'sd0, 1'b1, 1'b0, '0},
        '{16'sd0, -16'sd32768, 1'b1, 1'b0, '0},
        '{16'sd32767, -16'sd32768, 1'b1, 1'b0, '0},
        '{-16'sd32768, 16'sd32767, 1'b1, 1'b0, '0},
        '{16'sd1000, 16'sd0, 1'b0, 1'b0, '0},
        '{16'sd0, 16'sd1000, 1'b0, 1'b0, '0},
        '{16'sd1001, 16'sd0, 1'b1, 1'b0, '0},
        '{16'sd1, 16'sd1, 1'b0, 1'b0, '0},
        '{-16'sd1, -16'sd1, 1'b0, 1'b0, '0},
        '{16'sd1, -16'sd1, 1'b1, 1'b0, '0}
    };

    function automatic longint floor_shift(longint v, int k);
        return v >>> k;
    endfunction

    // vectoring CORDIC phase in Q1.16 turns
    function automatic longint phase_turns(longint si, longint sq);
        longint x, y, z, dx, dy;
        z = 0;
        if (si == 0 && sq == 0) return 0;
        x = si * 64'sd16777216;
        y = sq * 64'sd16777216;
        if (x < 0) begin
            z = (y >= 0) ? 32768 : -32768;
            x = -x;
            y = -y;
        end
        for (int k = 0; k < CordicSteps && k < 24; k++) begin
            dx = floor_shift(y, k);
            dy = floor_shift(x, k);
            if (y > 0) begin
                x += dx; y -= dy; z += TurnStep[k];
            end else begin
                x -= dx; y += dy; z -= TurnStep[k];
            end
        end
        if (z > 32768) z = 32768;
        if (z < -32768) z = -32768;
        return z;
    endfunction

    function automatic longint floor_root(longint v);
        longint r, t;
        r = 0;
        for (int b = 16; b >= 0; b--) begin
            t = r | (64'sd1 << b);
            if (t * t <= v) r = t;
        end
        return r;
    endfunction

    function automatic void clear_stats();
        n_samples = 0; n_in_band = 0; n_bad = 0;
        power_acc = 0; peak_pwr = 0; ovf_seen = 0;
    endfunction

    function automatic void shadow_write(t_reg_idx idx, logic [40:0] val);
        case (idx)
            REG_RATE:    rate_hz    = longint'(val[39:0]);
            REG_BAND_LO: band_lo_hz = longint'($signed(val));
            REG_BAND_HI: band_hi_hz = longint'($signed(val));
            REG_MAG:     mag_limit  = longint'(val[15:0]);
            default: ;
        endcase
    endfunction

    // fold one sample into the statistics; return 1 with a result on last
    function automatic bit absorb_sample(logic signed [15:0] si, logic signed [15:0] sq,
                                         bit last, output t_res r);
        longint iv, qv, p, f;
        bit band_ok;
        iv = si;
        qv = sq;
        band_ok = band_lo_hz <= band_hi_hz;
        r = '0;
        if (n_samples >= longint'(MaxSamples)) begin
            ovf_seen = 1;
        end else begin
            p = iv * iv + qv * qv;
            f = phase_turns(iv, qv) * rate_hz;
            n_samples++;
            if (f >= band_lo_hz * 65536 && f <= band_hi_hz * 65536) n_in_band++;
            if (p > mag_limit * mag_limit) n_bad++;
            power_acc += p;
            if (p > peak_pwr) peak_pwr = p;
        end
        if (!last) return 0;
        if (ovf_seen) begin
            r.status       = ST_TOO_MANY;
            r.sample_total = 24'(longint'(MaxSamples) + 1);
        end else begin
            r.status        = band_ok ? ST_OK : ST_BAND_BAD;
            r.sample_total  = 24'(n_samples);
            r.band_fraction = band_ok ? 17'((n_in_band * 65536) / n_samples) : 17'd0;
            r.clean_share   = 17'(((n_samples - n_bad) * 65536) / n_samples);
            r.power_avg     = 32'(power_acc / n_samples);
            r.peak_amp      = 16'(floor_root(peak_pwr));
        end
        clear_stats();
        return 1;
    endfunction

    // clock
    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    function automatic bit quiet_stretch();
        return samples_sent >= 600 && samples_sent < 800;
    endfunction

    // result side: random stalls plus one long hold-off
    initial begin
        m_out.ready = 1'b0;
        hold_off    = 1'b0;
    end
    always @(posedge i_clk) begin
        if (hold_off) begin
            m_out.ready <= 1'b0;
        end else begin
            m_out.ready <= quiet_stretch() || ($urandom_range(99) >= 15);
        end
    end

    initial begin
        wait (samples_sent >= 300);
        @(posedge i_clk);
        hold_off <= 1'b1;
        repeat (700) @(posedge i_clk);
        hold_off <= 1'b0;
    end

    // compare each result transaction with the oldest expectation
    always @(posedge i_clk) begin
        t_res got, want;
        if (i_rst_n && m_out.valid && m_out.ready) begin
            got = t_res'(m_out.data);
            if (pending_stats.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                err_count++;
            end else begin
                want = pending_stats.pop_front();
                if (got.status !== want.status) begin
                    $display("%0t: status exp %0d got %0d", $time, want.status, got.status);
                    err_count++;
                end
                if (got.sample_total !== want.sample_total) begin
                    $display("%0t: sample_total exp %0d got %0d", $time,
                             want.sample_total, got.sample_total);
                    err_count++;
                end
                if (got.band_fraction !== want.band_fraction) begin
                    $display("%0t: band_fraction exp %0d got %0d", $time,
                             want.band_fraction, got.band_fraction);
                    err_count++;
                end
                if (got.clean_share !== want.clean_share) begin
                    $display("%0t: clean_share exp %0d got %0d", $time,
                             want.clean_share, got.clean_share);
                    err_count++;
                end
                if (got.power_avg !== want.power_avg) begin
                    $display("%0t: power_avg exp %0d got %0d", $time,
                             want.power_avg, got.power_avg);
                    err_count++;
                end
                if (got.peak_amp !== want.peak_amp) begin
                    $display("%0t: peak_amp exp %0d got %0d", $time,
                             want.peak_amp, got.peak_amp);
                    err_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge i_clk) begin
        if ((s_in.valid && s_in.ready) || (m_out.valid && m_out.ready) || i_cfg_we) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= StallLimit) begin
            $display("FAILURE");
            $finish;
        end
    end

    // drive one register write; the caller drops the enable after the last one
    task automatic write_reg(t_reg_idx idx, logic [40:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        shadow_write(idx, val);
    endtask

    // offer one sample and hold it until accepted
    task automatic send_sample(logic signed [15:0] si, logic signed [15:0] sq, bit last,
                               bit typed, t_res typed_res);
        t_res r;
        if (!quiet_stretch() && $urandom_range(99) < 15) begin
            s_in.valid <= 1'b0;
            repeat ($urandom_range(3, 1)) @(posedge i_clk);
        end
        s_in.valid <= 1'b1;
        s_in.data  <= {si, sq, last};
        @(posedge i_clk);
        while (!s_in.ready) @(posedge i_clk);
        samples_sent++;
        if (absorb_sample(si, sq, last, r)) pending_stats.push_back(typed ? typed_res : r);
    endtask

    task automatic drain();
        s_in.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_stats.size() != 0) @(posedge i_clk);
        repeat (DrainWait) @(posedge i_clk);
    endtask

    function automatic logic [40:0] rand41();
        return 41'({$urandom, $urandom});
    endfunction

    function automatic logic signed [15:0] rand_component();
        int sel;
        sel = $urandom_range(9);
        if (sel < 5) return 16'($urandom);
        if (sel < 8) return $signed(16'($urandom_range(2400))) - 16'sd1200;
        if (sel == 8) return 16'sd0;
        return $urandom_range(1) ? 16'sd32767 : -16'sd32768;
    endfunction

    // pick the settings for one phase, extremes first
    task automatic configure_phase(int ph);
        longint r;
        case (ph)
            1: begin
                write_reg(REG_BAND_LO, 41'sd1000);
                write_reg(REG_BAND_HI, -41'sd1000);
            end
            2: begin
                write_reg(REG_RATE, 41'd0);
                write_reg(REG_BAND_LO, 41'sd0);
                write_reg(REG_BAND_HI, 41'sd0);
            end
            3: begin
                write_reg(REG_RATE, 41'd1000000000000);
                write_reg(REG_BAND_LO, -41'sd1000000000000);
                write_reg(REG_BAND_HI, 41'sd1000000000000);
                write_reg(REG_MAG, 41'd0);
            end
            4: begin
                write_reg(REG_RATE, 41'd1);
                write_reg(REG_BAND_LO, -41'sd0);
                write_reg(REG_BAND_HI, 41'sd0);
                write_reg(REG_MAG, 41'd46341);
            end
            5: begin
                write_reg(REG_RATE, rand41() & 41'hFF_FFFF_FFFF);
                write_reg(REG_BAND_LO, rand41());
                write_reg(REG_BAND_HI, rand41());
                write_reg(REG_MAG, 41'($urandom));
            end
            default: begin
                r = $urandom_range(1, 2000000);
                write_reg(REG_RATE, 41'(r));
                write_reg(REG_BAND_LO,
                          41'(-longint'($urandom_range(32'(r / 2 + 1)))));
                write_reg(REG_BAND_HI, 41'($urandom_range(32'(r / 2 + 1))));
                write_reg(REG_MAG, 41'($urandom_range(2000)));
            end
        endcase
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        int ph, len;
        err_count    = 0;
        samples_sent = 0;
        idle_cycles  = 0;
        s_in.valid   = 1'b0;
        s_in.data    = '0;
        i_cfg_we     = 1'b0;
        i_cfg_idx    = REG_RATE;
        i_cfg_data   = '0;
        i_rst_n      = 1'b0;
        rate_hz = 1000000; band_lo_hz = -500000; band_hi_hz = 500000; mag_limit = 1000;
        clear_stats();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // walk the directed rows with reset settings
        foreach (dir_rows[k])
            send_sample(dir_rows[k].i_val, dir_rows[k].q_val, dir_rows[k].last,
                        dir_rows[k].typed, dir_rows[k].res);

        // random buffers, reconfigured between phases
        ph = 1;
        while (samples_sent < ItemTarget) begin
            drain();
            configure_phase(ph);
            repeat (8) begin
                len = ($urandom_range(9) == 0) ? $urandom_range(60, 17)
                                               : $urandom_range(16, 1);
                for (int s = 1; s <= len; s++)
                    send_sample(rand_component(), rand_component(), s == len, 1'b0, '0);
            end
            ph++;
        end
        drain();

        if (err_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
hdl/iqs_pkg.sv
hdl/iqs_stream_if.sv
hdl/iqs_front.sv
hdl/iqs_queue.sv
hdl/iqs_back.sv
hdl/iq_stream_statistics_top.sv
tb/tb_iq_stream_statistics_top.sv
